@@ rtl/four_voice_sample_mixer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the four-voice sample mixer
// Immediate-consequence and next-cycle forms; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FOUR_VOICE_SAMPLE_MIXER_TOP_ASSERT_SVH
`define FOUR_VOICE_SAMPLE_MIXER_TOP_ASSERT_SVH

`ifndef SYNTH
// Consequence must hold in the same cycle as the antecedent
`define FVSM_ASSERT_SAME(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fvsm assertion failed");
// Consequence must hold in the cycle after the antecedent
`define FVSM_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fvsm assertion failed");
`else
`define FVSM_ASSERT_SAME(name, ck, rn, ante, cons)
`define FVSM_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif

`endif

@@ rtl/fvsm_pkg.sv @@
// ----------------------------------------------------------------------------
// fvsm_pkg
// Shared constants, codes and control types of the four-voice sample mixer.
// ----------------------------------------------------------------------------
package fvsm_pkg;

  // Voice organization
  localparam int VOICE_COUNT = 4;
  localparam int VOICE_DEPTH = 16384;
  localparam int STORE_WORDS = VOICE_COUNT * VOICE_DEPTH;

  // Channel field widths
  localparam int MODE_W   = 2;
  localparam int VOICE_W  = 2;
  localparam int ADDR_W   = 14;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 15;
  localparam int ACTIVE_W = 4;

  // Derived internal widths
  localparam int VC_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VSEL_W = (VC_W > VOICE_W) ? VC_W : VOICE_W;
  localparam int POS_W  = $clog2(VOICE_DEPTH + 1);
  localparam int SA_W   = $clog2(STORE_WORDS);
  localparam int ACC_W  = SAMPLE_W + VC_W + 1;

  localparam logic [VC_W-1:0] VC_LAST = VC_W'(VOICE_COUNT - 1);

  // Mix clamp limits
  localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIX_MIN = ACC_W'(-32767);

  // Item mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_TRIGGER = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_LOAD    = 2'd3
  } mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_TRIGGER,
    OP_WRITE,
    OP_LOAD
  } op_t;

  // Controller to datapath
  typedef struct packed {
    op_t             op;
    logic [VC_W-1:0] voice;
    logic            first;
    logic            load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ rtl/fvsm_if.sv @@
// ----------------------------------------------------------------------------
// fvsm_in_if / fvsm_out_if
// Valid/ready channels carrying mixer items and mixed results.
// ----------------------------------------------------------------------------
interface fvsm_in_if;
  import fvsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [VOICE_W-1:0]         voice;
  logic [ADDR_W-1:0]          word_address;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [COUNT_W-1:0]         sample_count;

  modport source (
    output valid, mode, voice, word_address, sample_value, sample_count,
    input  ready
  );

  modport sink (
    input  valid, mode, voice, word_address, sample_value, sample_count,
    output ready
  );
endinterface

interface fvsm_out_if;
  import fvsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic [ACTIVE_W-1:0]        active_voices;

  modport source (
    output valid, mixed_sample, active_voices,
    input  ready
  );

  modport sink (
    input  valid, mixed_sample, active_voices,
    output ready
  );
endinterface

@@ rtl/fvsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fvsm_ctrl
// Item decode and tick sequencer: steps the voices and hands off the mix.
// ----------------------------------------------------------------------------
module fvsm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [fvsm_pkg::MODE_W-1:0]   in_mode,
  input  logic [fvsm_pkg::VOICE_W-1:0]  in_voice,
  input  logic [fvsm_pkg::ADDR_W-1:0]   in_word_address,
  output logic                          in_ready,
  input  fvsm_pkg::status_t             status,
  output fvsm_pkg::cmd_t                cmd
);
  import fvsm_pkg::*;

  state_t            state_r, state_nxt;
  logic [VC_W-1:0]   cnt_r, cnt_nxt;
  logic [VSEL_W-1:0] voice_ext;
  logic              voice_ok;
  logic              addr_ok;
  logic              is_tick;

  // Decode addressing checks
  assign voice_ext = VSEL_W'(in_voice);
  assign voice_ok  = 32'(voice_ext) < 32'(VOICE_COUNT);
  assign addr_ok   = 32'(in_word_address) < 32'(VOICE_DEPTH);
  assign is_tick   = in_valid && (mode_t'(in_mode) == MODE_TICK);

  // State and voice counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_tick) begin
          cnt_nxt   = VC_W'(1);
          state_nxt = (VOICE_COUNT == 1) ? ST_DONE : ST_MIX;
        end
      end
      ST_MIX: begin
        if (cnt_r == VC_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs: voice 0 is stepped in the accept cycle itself
  always_comb begin
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.voice    = '0;
    cmd.first    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mode_t'(in_mode))
            MODE_TICK: begin
              cmd.op    = OP_TICK;
              cmd.first = 1'b1;
            end
            MODE_TRIGGER: begin
              if (voice_ok) begin
                cmd.op    = OP_TRIGGER;
                cmd.voice = voice_ext[VC_W-1:0];
              end
            end
            MODE_WRITE: begin
              if (voice_ok && addr_ok) begin
                cmd.op    = OP_WRITE;
                cmd.voice = voice_ext[VC_W-1:0];
              end
            end
            MODE_LOAD: begin
              if (voice_ok) begin
                cmd.op    = OP_LOAD;
                cmd.voice = voice_ext[VC_W-1:0];
              end
            end
          endcase
        end
      end
      ST_MIX: begin
        cmd.op    = OP_TICK;
        cmd.voice = cnt_r;
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/fvsm_datapath.sv @@
// ----------------------------------------------------------------------------
// fvsm_datapath
// Sample store, per-voice play state, mix accumulator and result register.
// ----------------------------------------------------------------------------
module fvsm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fvsm_pkg::cmd_t                      cmd,
  input  logic [fvsm_pkg::ADDR_W-1:0]         in_word_address,
  input  logic signed [fvsm_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [fvsm_pkg::COUNT_W-1:0]        in_sample_count,
  output fvsm_pkg::status_t                   status,
  fvsm_out_if.source                          out_ch
);
  import fvsm_pkg::*;

  localparam int ACT_N = (VOICE_COUNT < ACTIVE_W) ? VOICE_COUNT : ACTIVE_W;

  logic [SAMPLE_W-1:0]        store_mem [0:STORE_WORDS-1];
  logic [POS_W-1:0]           pos_r [VOICE_COUNT];
  logic [POS_W-1:0]           len_r [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]     playing_r;
  logic [VOICE_COUNT-1:0]     ready_r;

  logic [POS_W-1:0]           sel_pos;
  logic                       voice_hit;
  logic [SA_W-1:0]            voice_base;
  logic [SA_W-1:0]            rd_addr;
  logic [SA_W-1:0]            wr_addr;
  logic [POS_W-1:0]           len_load;

  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       issue_r;
  logic                       first_r;
  logic                       contrib_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] mix_clamped;
  logic [ACTIVE_W-1:0]        active_nxt;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_mixed_r;
  logic [ACTIVE_W-1:0]        out_active_r;

  // Voice selection and store addressing
  assign sel_pos    = pos_r[cmd.voice];
  assign voice_hit  = playing_r[cmd.voice] && ready_r[cmd.voice] &&
                      (sel_pos < len_r[cmd.voice]);
  assign voice_base = SA_W'(cmd.voice) * SA_W'(VOICE_DEPTH);
  assign rd_addr    = voice_base + SA_W'(sel_pos);
  assign wr_addr    = voice_base + SA_W'(in_word_address);

  // Saturate load length to the voice depth
  assign len_load = (32'(in_sample_count) > 32'(VOICE_DEPTH)) ?
                    POS_W'(VOICE_DEPTH) : POS_W'(in_sample_count);

  // Sample store write port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      store_mem[wr_addr] <= in_sample_value;
    end
  end

  // Sample store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TICK) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Per-voice play state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= '0;
      ready_r   <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        pos_r[i] <= '0;
        len_r[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        OP_TICK: begin
          if (voice_hit) begin
            pos_r[cmd.voice] <= sel_pos + 1'b1;
          end else begin
            playing_r[cmd.voice] <= 1'b0;
          end
        end
        OP_TRIGGER: begin
          if (ready_r[cmd.voice]) begin
            pos_r[cmd.voice]     <= '0;
            playing_r[cmd.voice] <= 1'b1;
          end
        end
        OP_WRITE: begin
          ready_r[cmd.voice]   <= 1'b0;
          playing_r[cmd.voice] <= 1'b0;
        end
        OP_LOAD: begin
          len_r[cmd.voice]     <= len_load;
          pos_r[cmd.voice]     <= '0;
          playing_r[cmd.voice] <= 1'b0;
          ready_r[cmd.voice]   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Track which step is in the read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      first_r   <= 1'b0;
      contrib_r <= 1'b0;
    end else begin
      issue_r   <= (cmd.op == OP_TICK);
      first_r   <= cmd.first;
      contrib_r <= (cmd.op == OP_TICK) && voice_hit;
    end
  end

  // Accumulate one voice per cycle, in the cycle after its read is issued
  assign term     = (issue_r && contrib_r) ? ACC_W'(rd_data_r) : '0;
  assign acc_base = (issue_r && first_r) ? '0 : acc_r;
  assign acc_sum  = acc_base + term;

  always_ff @(posedge clk) begin
    if (issue_r) begin
      acc_r <= acc_sum;
    end
  end

  // Clamp the mix
  always_comb begin
    priority if (acc_sum > MIX_MAX) begin
      mix_clamped = SAMPLE_W'(MIX_MAX);
    end else if (acc_sum < MIX_MIN) begin
      mix_clamped = SAMPLE_W'(MIX_MIN);
    end else begin
      mix_clamped = SAMPLE_W'(acc_sum);
    end
  end

  // Playing marks after the tick
  always_comb begin
    active_nxt = '0;
    for (int i = 0; i < ACT_N; i++) begin
      active_nxt[i] = playing_r[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mixed_r  <= mix_clamped;
      out_active_r <= active_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mixed_sample  = out_mixed_r;
  assign out_ch.active_voices = out_active_r;
  assign status.out_free      = !out_valid_r || out_ch.ready;

endmodule

@@ rtl/four_voice_sample_mixer_top.sv @@
// ----------------------------------------------------------------------------
// four_voice_sample_mixer_top
// Four one-shot sample voices summed and clamped into one output stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: a sample word write, a finish-load
//   with length, a voice trigger or an output tick. Only a tick makes a
//   result; out_ch carries the clamped mix and the playing mask.
//   Write, load and trigger items are taken in the idle state; the next transfer
//   can follow in the next cycle.
//   A tick steps the voices in turn through the single read port of the sample
//   store, then clamps the mix and loads it into the output register.
//   The result sits in an output register; write, load and trigger items are
//   still taken while it waits. A tick that finishes while the receiver
//   stalls holds in its last step until the register is free.
//   Reset clears all voice marks, positions and lengths. The sample store is
//   not cleared; play only words that were written. No reset sweep is needed.
// ----------------------------------------------------------------------------
`include "four_voice_sample_mixer_top_assert.svh"

module four_voice_sample_mixer_top (
  input  logic      clk,
  input  logic      rst_n,
  fvsm_in_if.sink   in_ch,
  fvsm_out_if.source out_ch
);
  import fvsm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Controller
  fvsm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_mode         (in_ch.mode),
    .in_voice        (in_ch.voice),
    .in_word_address (in_ch.word_address),
    .in_ready        (in_ready),
    .status          (status),
    .cmd             (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath
  fvsm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_word_address (in_ch.word_address),
    .in_sample_value (in_ch.sample_value),
    .in_sample_count (in_ch.sample_count),
    .status          (status),
    .out_ch          (out_ch)
  );

  // A result appears only when the controller loads the mix
  `FVSM_ASSERT_SAME(a_out_from_load, clk, rst_n, $rose(out_ch.valid), $past(cmd.load_out))
  // A tick closes the input channel for its remaining steps
  `FVSM_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_ch.valid && in_ch.ready && (in_ch.mode == MODE_TICK), !in_ch.ready)
  // Later voice steps run only while no item is taken
  `FVSM_ASSERT_SAME(a_step_closed, clk, rst_n, (cmd.op == OP_TICK) && !cmd.first, !in_ch.ready)

endmodule

@@ verif/four_voice_sample_mixer_checker.sv @@
// ----------------------------------------------------------------------------
// four_voice_sample_mixer_checker
// Watches the item and mix channels of the four-voice sample mixer, keeps its
// own copy of the voice stores and marks, predicts one mix per accepted tick
// and compares every mix transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module four_voice_sample_mixer_checker (
  input  logic        clk,
  input  logic        rst_n,
  fvsm_in_if          in_ch,
  fvsm_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned waiting,
  output int unsigned checked,
  output int unsigned clamped
);
  import fvsm_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mix;
    logic [ACTIVE_W-1:0]        active;
  } mix_exp_t;

  // Shadow voice state
  logic signed [SAMPLE_W-1:0] voice_mem [0:STORE_WORDS-1];
  logic [POS_W-1:0]           cur_pos   [VOICE_COUNT];
  logic [POS_W-1:0]           cur_len   [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]     playing;
  logic [VOICE_COUNT-1:0]     loaded;

  mix_exp_t expected_mixes [$];

  initial begin
    mismatches = 0;
    waiting    = 0;
    checked    = 0;
    clamped    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Sum the contributing voices, advance or stop each one, clamp the sum
  function automatic mix_exp_t mix_tick();
    mix_exp_t r;
    int       acc;
    acc      = 0;
    r.active = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (playing[v] && loaded[v] && cur_pos[v] < cur_len[v]) begin
        acc += voice_mem[v * VOICE_DEPTH + int'(cur_pos[v])];
        cur_pos[v] = cur_pos[v] + 1'b1;
      end else begin
        playing[v] = 1'b0;
      end
      if (v < ACTIVE_W) r.active[v] = playing[v];
    end
    if (acc > 32767 || acc < -32767) clamped++;
    if (acc > 32767) acc = 32767;
    if (acc < -32767) acc = -32767;
    r.mix = SAMPLE_W'(acc);
    return r;
  endfunction

  always @(posedge clk) begin
    mix_exp_t e;
    int       idx;
    if (!rst_n) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        cur_pos[v] = '0;
        cur_len[v] = '0;
      end
      playing = '0;
      loaded  = '0;
      expected_mixes.delete();
    end else begin
      // Compare a mix transfer with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_mixes.size() == 0) begin
          report_mismatch($sformatf("unexpected mix %0d active %b",
                                    out_ch.mixed_sample, out_ch.active_voices));
        end else begin
          e = expected_mixes.pop_front();
          checked++;
          if (out_ch.mixed_sample !== e.mix)
            report_mismatch($sformatf("mixed_sample got %0d exp %0d",
                                      out_ch.mixed_sample, e.mix));
          if (out_ch.active_voices !== e.active)
            report_mismatch($sformatf("active_voices got %b exp %b",
                                      out_ch.active_voices, e.active));
        end
      end

      // Apply an item transfer to the shadow state
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_TICK) begin
          expected_mixes.push_back(mix_tick());
        end else if (int'(in_ch.voice) < VOICE_COUNT) begin
          case (in_ch.mode)
            MODE_TRIGGER: begin
              if (loaded[in_ch.voice]) begin
                cur_pos[in_ch.voice] = '0;
                playing[in_ch.voice] = 1'b1;
              end
            end
            MODE_WRITE: begin
              if (int'(in_ch.word_address) < VOICE_DEPTH) begin
                idx = int'(in_ch.voice) * VOICE_DEPTH + int'(in_ch.word_address);
                voice_mem[idx]       = in_ch.sample_value;
                loaded[in_ch.voice]  = 1'b0;
                playing[in_ch.voice] = 1'b0;
              end
            end
            default: begin
              // Finish load: saturate the length to the voice depth
              if (int'(in_ch.sample_count) > VOICE_DEPTH)
                cur_len[in_ch.voice] = POS_W'(VOICE_DEPTH);
              else
                cur_len[in_ch.voice] = POS_W'(in_ch.sample_count);
              cur_pos[in_ch.voice] = '0;
              playing[in_ch.voice] = 1'b0;
              loaded[in_ch.voice]  = 1'b1;
            end
          endcase
        end
      end
    end
    waiting = expected_mixes.size();
  end

endmodule

@@ verif/four_voice_sample_mixer_top_tb.sv @@
// ----------------------------------------------------------------------------
// four_voice_sample_mixer_top_tb
// Drives directed and random item streams into the four-voice sample mixer
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module four_voice_sample_mixer_top_tb;
  import fvsm_pkg::*;

  localparam int TOTAL_ITEMS = 1275;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 32;

  logic clk;
  logic rst_n;

  fvsm_in_if  in_ch ();
  fvsm_out_if out_ch ();

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned checked;
  int unsigned clamped;

  four_voice_sample_mixer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  four_voice_sample_mixer_checker mix_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked),
    .clamped    (clamped)
  );

  // Stimulus-side view of the voices, kept only to avoid playing unwritten words
  bit stored     [VOICE_COUNT][VOICE_DEPTH];
  int prefix     [VOICE_COUNT];
  int sh_pos     [VOICE_COUNT];
  int sh_len     [VOICE_COUNT];
  bit sh_playing [VOICE_COUNT];
  bit sh_ready   [VOICE_COUNT];

  int items_sent;
  int ticks_sent;
  int idle_cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int load_count(input int p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, p);
    if (r < 85) return $urandom_range(0, 32767);
    if (r < 92) return VOICE_DEPTH + $urandom_range(0, 16383);
    return p + $urandom_range(1, 20);
  endfunction

  // Follow the voice marks after each accepted item
  task automatic update_shadow(input mode_t m, input int v, input int addr, input int cnt);
    case (m)
      MODE_TICK: begin
        for (int i = 0; i < VOICE_COUNT; i++) begin
          if (sh_playing[i] && sh_ready[i] && sh_pos[i] < sh_len[i]) sh_pos[i]++;
          else sh_playing[i] = 1'b0;
        end
      end
      MODE_TRIGGER: begin
        if (sh_ready[v]) begin
          sh_pos[v]     = 0;
          sh_playing[v] = 1'b1;
        end
      end
      MODE_WRITE: begin
        stored[v][addr] = 1'b1;
        while (prefix[v] < VOICE_DEPTH && stored[v][prefix[v]]) prefix[v]++;
        sh_ready[v]   = 1'b0;
        sh_playing[v] = 1'b0;
      end
      default: begin
        sh_len[v]     = (cnt > VOICE_DEPTH) ? VOICE_DEPTH : cnt;
        sh_pos[v]     = 0;
        sh_playing[v] = 1'b0;
        sh_ready[v]   = 1'b1;
      end
    endcase
  endtask

  // Present one item, hold it until the transfer, keep valid high when back to back
  task automatic send_item(input mode_t m, input int v, input int addr, input int val,
                           input int cnt);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.voice        <= VOICE_W'(v);
    in_ch.word_address <= ADDR_W'(addr);
    in_ch.sample_value <= SAMPLE_W'(val);
    in_ch.sample_count <= COUNT_W'(cnt);
    do @(posedge clk); while (!in_ch.ready);
    update_shadow(m, v, addr, cnt);
    items_sent++;
    if (m == MODE_TICK) ticks_sent++;
  endtask

  // Extend any voice about to read past its written words, then tick
  task automatic send_tick();
    for (int v = 0; v < VOICE_COUNT; v++)
      if (sh_playing[v] && sh_ready[v] && sh_pos[v] < sh_len[v] && sh_pos[v] >= prefix[v])
        send_item(MODE_WRITE, v, prefix[v], rand_sample(), $urandom_range(0, 32767));
    send_item(MODE_TICK, $urandom_range(0, 3), $urandom_range(0, 16383), rand_sample(),
              $urandom_range(0, 32767));
  endtask

  task automatic send_trigger(input int v);
    send_item(MODE_TRIGGER, v, $urandom_range(0, 16383), rand_sample(),
              $urandom_range(0, 32767));
  endtask

  task automatic send_write(input int v, input int addr, input int val);
    send_item(MODE_WRITE, v, addr, val, $urandom_range(0, 32767));
  endtask

  task automatic send_load(input int v, input int cnt);
    send_item(MODE_LOAD, v, $urandom_range(0, 16383), rand_sample(), cnt);
  endtask

  // Rewrite a voice from word zero, finish the load and usually start it
  task automatic reload_voice(input int v);
    int n;
    n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    for (int a = 0; a < n; a++) begin
      if ($urandom_range(0, 99) < 15) send_tick();
      send_write(v, a, rand_sample());
    end
    send_load(v, load_count(prefix[v]));
    if ($urandom_range(0, 99) < 85) send_trigger(v);
  endtask

  // Result side: ready with random stalls
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d mixes pending",
                 idle_cycles, waiting);
        $display("four_voice_sample_mixer_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int v;
    items_sent  = 0;
    ticks_sent  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      prefix[i]     = 0;
      sh_pos[i]     = 0;
      sh_len[i]     = 0;
      sh_playing[i] = 1'b0;
      sh_ready[i]   = 1'b0;
    end
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_TICK;
    in_ch.voice        <= '0;
    in_ch.word_address <= '0;
    in_ch.sample_value <= '0;
    in_ch.sample_count <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, trigger before load, clamping both ways
    send_tick();
    send_trigger(0);
    send_write(0, 0, 32767);
    send_write(0, 1, -32768);
    send_write(1, 0, 32767);
    send_write(1, 1, -32768);
    send_load(0, 2);
    send_load(1, 2);
    send_trigger(0);
    send_trigger(1);
    send_tick();
    send_tick();
    send_tick();
    // Zero length: starts, then stops on the next tick without adding
    send_load(2, 0);
    send_trigger(2);
    send_tick();
    // Length of the full voice depth; a write stops a playing voice
    send_write(3, 0, -1);
    send_load(3, VOICE_DEPTH);
    send_trigger(3);
    send_tick();
    send_write(3, 1, 16'h1234);
    send_trigger(3);
    send_tick();

    // Random: mostly reload-trigger-play sequences with noise mixed in
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 79) == 0) calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      v    = $urandom_range(0, VOICE_COUNT - 1);
      if (pick < 45) send_tick();
      else if (pick < 55) send_trigger(v);
      else if (pick < 80) reload_voice(v);
      else if (pick < 90) send_load(v, load_count(prefix[v]));
      else send_write(v, $urandom_range(0, 16383), rand_sample());
    end

    // Drain outstanding mixes, then let the block settle
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Summary: %0d items sent, %0d of them ticks; %0d mixes checked, %0d clamped",
             items_sent, ticks_sent, checked, clamped);
    $display("Summary: %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("four_voice_sample_mixer_top_tb OK");
    else
      $display("four_voice_sample_mixer_top_tb NOT OK");
    $finish;
  end

endmodule
